// ===== src/rvm_pkg.sv =====
// shared types, constants and helpers of the rotation vector to matrix block
// no dependencies
package rvm_pkg;

  localparam int IN_W          = 24;
  localparam int OUT_W         = 24;
  localparam int LIMIT_W       = 21;
  localparam int LEN_W         = 24;
  localparam int RAD_W         = 2 * LEN_W;
  localparam int SQRT_STEPS    = LEN_W;
  localparam int DIV_BITS      = 31;
  localparam int CORD_W        = 34;
  localparam int DEF_CORDIC_STAGES = 24;
  localparam int DEF_FRAC_BITS     = 22;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1;

  // angle, cordic gain and unit constants in Q.30
  localparam logic [34:0] TWO_PI_Q30   = 35'd6746518852;
  localparam logic [34:0] FOUR_PI_Q30  = 35'd13493037704;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [34:0] Q30_ONE = 35'sd1073741824;

  typedef struct packed {
    logic signed [IN_W-1:0] axis_x;
    logic signed [IN_W-1:0] axis_y;
    logic signed [IN_W-1:0] axis_z;
  } rvm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
    logic                    was_identity;
  } rvm_out_t;

  // square root recurrence state
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [LEN_W+1:0] rem;
    logic [LEN_W-1:0] root;
  } sqrt_t;

  // three divider lanes sharing one divisor
  typedef struct packed {
    logic [2:0][LEN_W:0]      rem;
    logic [2:0][DIV_BITS-1:0] quo;
    logic [LEN_W-1:0]         len;
  } div_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } cordic_t;

  // truncated atan(2^-i) in Q.30
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd7;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Q.30 product with floor shift
  function automatic logic signed [39:0] mulq(input logic signed [39:0] a,
                                              input logic signed [39:0] b);
    logic signed [79:0] ae;
    logic signed [79:0] be;
    logic signed [79:0] p;
    ae = a;
    be = b;
    p  = ae * be;
    return p[69:30];
  endfunction

endpackage

// ===== src/rvm_sqrt_cell.sv =====
// one step of the pipelined integer square root, two radicand bits per cell
// depends on rvm_pkg
module rvm_sqrt_cell #(
  parameter int SIDE_W = 72
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rvm_pkg::sqrt_t      st_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output rvm_pkg::sqrt_t      st_o,
  output logic [SIDE_W-1:0]   side_o
);
  import rvm_pkg::*;

  logic [LEN_W+3:0] rem_sh;
  logic [LEN_W+3:0] trial;
  logic [LEN_W+3:0] diff;
  sqrt_t            st_d;
  sqrt_t            st_q;
  logic             valid_q;
  logic [SIDE_W-1:0] side_q;

  // trial subtract of 4*root+1
  always_comb begin
    rem_sh = {st_i.rem, st_i.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, st_i.root, 2'b01};
    diff   = rem_sh - trial;
    st_d.rad = {st_i.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      st_d.rem  = diff[LEN_W+1:0];
      st_d.root = {st_i.root[LEN_W-2:0], 1'b1};
    end else begin
      st_d.rem  = rem_sh[LEN_W+1:0];
      st_d.root = {st_i.root[LEN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign side_o  = side_q;

endmodule

// ===== src/rvm_div_cell.sv =====
// one quotient bit of the three-lane restoring divider
// depends on rvm_pkg
module rvm_div_cell #(
  parameter int SIDE_W = 37
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rvm_pkg::div_t       st_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output rvm_pkg::div_t       st_o,
  output logic [SIDE_W-1:0]   side_o
);
  import rvm_pkg::*;

  div_t              st_d;
  div_t              st_q;
  logic              valid_q;
  logic [SIDE_W-1:0] side_q;
  logic [LEN_W:0]    r_n [3];
  logic              qb  [3];

  // compare, subtract, shift in a zero
  always_comb begin
    st_d.len = st_i.len;
    for (int l = 0; l < 3; l++) begin
      qb[l]  = st_i.rem[l] >= {1'b0, st_i.len};
      r_n[l] = qb[l] ? (st_i.rem[l] - {1'b0, st_i.len}) : st_i.rem[l];
      st_d.rem[l] = {r_n[l][LEN_W-1:0], 1'b0};
      st_d.quo[l] = {st_i.quo[l][DIV_BITS-2:0], qb[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign side_o  = side_q;

endmodule

// ===== src/rvm_cordic_cell.sv =====
// one rotation-mode cordic micro-rotation with a fixed shift
// depends on rvm_pkg
module rvm_cordic_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 98
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rvm_pkg::cordic_t    st_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output rvm_pkg::cordic_t    st_o,
  output logic [SIDE_W-1:0]   side_o
);
  import rvm_pkg::*;

  cordic_t                  st_d;
  cordic_t                  st_q;
  logic                     valid_q;
  logic [SIDE_W-1:0]        side_q;
  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;
  logic signed [CORD_W-1:0] at;

  // rotate toward zero residual angle
  always_comb begin
    dx = st_i.y >>> IDX;
    dy = st_i.x >>> IDX;
    at = CORD_W'(atan_q30(IDX));
    if (!st_i.z[CORD_W-1]) begin
      st_d.x = st_i.x - dx;
      st_d.y = st_i.y + dy;
      st_d.z = st_i.z - at;
    end else begin
      st_d.x = st_i.x + dx;
      st_d.y = st_i.y - dy;
      st_d.z = st_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign side_o  = side_q;

endmodule

// ===== src/rotation_vector_to_matrix.sv =====
// channel | dir | signals                         | moves
// in      | in  | in_valid_i in_ready_o in_data_i | rotation vector item
// out     | out | out_valid_o out_ready_i out_data_o | 3x3 matrix item
// cfg     | in  | cfg_valid_i cfg_ready_o cfg_data_i | small angle limit
//
// one item per cycle while no result is held at the output; items pass in order through
// squares, square root, divider and cordic cell chains, products and output register
// reset clears all valid bits and sets the limit to one lsb
// a held result at the output freezes the whole chain; in_ready_o drops with it
// cfg_ready_o is always high
// top level of the rotation vector to matrix block, depends on rvm_pkg and cells
module rotation_vector_to_matrix
  import rvm_pkg::*;
#(
  parameter int CORDIC_STAGES = rvm_pkg::DEF_CORDIC_STAGES,
  parameter int FRAC_BITS     = rvm_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rvm_pkg::rvm_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rvm_pkg::rvm_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rvm_pkg::LIMIT_W-1:0]   cfg_data_i
);

  localparam int SQ_SIDE_W  = 3 * IN_W;
  localparam int DIV_SIDE_W = 1 + 3 + 33;
  localparam int COR_SIDE_W = 2 + 3 * 32;
  localparam int SH         = 30 - FRAC_BITS;
  localparam logic signed [37:0] ONE = 38'sd1 <<< FRAC_BITS;
  localparam logic signed [37:0] RND = (SH > 0) ? (38'sd1 <<< ((SH > 0) ? SH - 1 : 0))
                                                : 38'sd0;

  logic en;
  logic [LIMIT_W-1:0] limit_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  // global advance whenever the output register can move
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // squares
  logic              s1_valid_q, s2_valid_q;
  logic [46:0]       sq_q [3];
  rvm_in_t           s1_a_q, s2_a_q;
  logic [RAD_W-1:0]  sum_q;
  logic signed [47:0] ex [3];

  always_comb begin
    ex[0] = in_data_i.axis_x;
    ex[1] = in_data_i.axis_y;
    ex[2] = in_data_i.axis_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sq_q[l] <= 47'(ex[l] * ex[l]);
      end
      s1_a_q <= in_data_i;
      sum_q  <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
      s2_a_q <= s1_a_q;
    end
  end

  // square root chain
  logic                 sq_valid [SQRT_STEPS+1];
  sqrt_t                sq_st    [SQRT_STEPS+1];
  logic [SQ_SIDE_W-1:0] sq_side  [SQRT_STEPS+1];

  assign sq_valid[0]    = s2_valid_q;
  assign sq_st[0].rad   = sum_q;
  assign sq_st[0].rem   = '0;
  assign sq_st[0].root  = '0;
  assign sq_side[0]     = s2_a_q;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    rvm_sqrt_cell #(.SIDE_W(SQ_SIDE_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sq_valid[g]), .st_i(sq_st[g]), .side_i(sq_side[g]),
      .valid_o(sq_valid[g+1]), .st_o(sq_st[g+1]), .side_o(sq_side[g+1])
    );
  end

  // identity decision, axis magnitudes, coarse angle reduction
  rvm_in_t          d0_a;
  logic [LEN_W-1:0] d0_len;
  logic [33:0]      theta0;
  logic [34:0]      theta1;
  logic [LEN_W-1:0] mag [3];
  logic             d0_valid_q;
  div_t             d0_st_q;
  logic [DIV_SIDE_W-1:0] d0_side_q;

  always_comb begin
    d0_a   = sq_side[SQRT_STEPS];
    d0_len = sq_st[SQRT_STEPS].root;
    theta0 = {d0_len, 10'b0};
    if ({1'b0, theta0} >= FOUR_PI_Q30) begin
      theta1 = {1'b0, theta0} - FOUR_PI_Q30;
    end else if ({1'b0, theta0} >= TWO_PI_Q30) begin
      theta1 = {1'b0, theta0} - TWO_PI_Q30;
    end else begin
      theta1 = {1'b0, theta0};
    end
    mag[0] = d0_a.axis_x[IN_W-1] ? (~d0_a.axis_x + 24'd1) : d0_a.axis_x;
    mag[1] = d0_a.axis_y[IN_W-1] ? (~d0_a.axis_y + 24'd1) : d0_a.axis_y;
    mag[2] = d0_a.axis_z[IN_W-1] ? (~d0_a.axis_z + 24'd1) : d0_a.axis_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_valid_q <= 1'b0;
    end else if (en) begin
      d0_valid_q <= sq_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        d0_st_q.rem[l] <= {1'b0, mag[l]};
        d0_st_q.quo[l] <= '0;
      end
      d0_st_q.len <= d0_len;
      d0_side_q   <= {(d0_len == '0) || (d0_len < {3'b000, limit_q}),
                      d0_a.axis_x[IN_W-1], d0_a.axis_y[IN_W-1], d0_a.axis_z[IN_W-1],
                      theta1[32:0]};
    end
  end

  // divider chain
  logic                  dv_valid [DIV_BITS+1];
  div_t                  dv_st    [DIV_BITS+1];
  logic [DIV_SIDE_W-1:0] dv_side  [DIV_BITS+1];

  assign dv_valid[0] = d0_valid_q;
  assign dv_st[0]    = d0_st_q;
  assign dv_side[0]  = d0_side_q;

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    rvm_div_cell #(.SIDE_W(DIV_SIDE_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv_valid[g]), .st_i(dv_st[g]), .side_i(dv_side[g]),
      .valid_o(dv_valid[g+1]), .st_o(dv_st[g+1]), .side_o(dv_side[g+1])
    );
  end

  // signed axis and folded angle for the cordic
  logic [DIV_SIDE_W-1:0] c0_sd;
  logic signed [31:0]    nv [3];
  logic signed [34:0]    th_a;
  logic signed [34:0]    th_b;
  logic                  neg_cos;
  logic                  c0_valid_q;
  cordic_t               c0_st_q;
  logic [COR_SIDE_W-1:0] c0_side_q;

  always_comb begin
    c0_sd = dv_side[DIV_BITS];
    for (int l = 0; l < 3; l++) begin
      nv[l] = c0_sd[35-l] ? -$signed({1'b0, dv_st[DIV_BITS].quo[l]})
                          : $signed({1'b0, dv_st[DIV_BITS].quo[l]});
    end
    th_a = $signed({2'b00, c0_sd[32:0]});
    if (th_a > PI_Q30) begin
      th_a = th_a - $signed(TWO_PI_Q30);
    end
    neg_cos = 1'b0;
    th_b    = th_a;
    if (th_a > HALF_PI_Q30) begin
      th_b    = PI_Q30 - th_a;
      neg_cos = 1'b1;
    end else if (th_a < -HALF_PI_Q30) begin
      th_b    = -PI_Q30 - th_a;
      neg_cos = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_valid_q <= 1'b0;
    end else if (en) begin
      c0_valid_q <= dv_valid[DIV_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_st_q.x <= CORDIC_GAIN_Q30;
      c0_st_q.y <= '0;
      c0_st_q.z <= th_b[CORD_W-1:0];
      c0_side_q <= {c0_sd[36], neg_cos, nv[0], nv[1], nv[2]};
    end
  end

  // cordic chain
  logic                  cr_valid [CORDIC_STAGES+1];
  cordic_t               cr_st    [CORDIC_STAGES+1];
  logic [COR_SIDE_W-1:0] cr_side  [CORDIC_STAGES+1];

  assign cr_valid[0] = c0_valid_q;
  assign cr_st[0]    = c0_st_q;
  assign cr_side[0]  = c0_side_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rvm_cordic_cell #(.IDX(g), .SIDE_W(COR_SIDE_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cr_valid[g]), .st_i(cr_st[g]), .side_i(cr_side[g]),
      .valid_o(cr_valid[g+1]), .st_o(cr_st[g+1]), .side_o(cr_side[g+1])
    );
  end

  // axis products and sine terms
  logic [COR_SIDE_W-1:0]    p1_sd;
  logic signed [31:0]       p1_n [3];
  logic signed [CORD_W-1:0] p1_c;
  logic                     p1_valid_q, p2_valid_q;
  logic                     p1_id_q, p2_id_q;
  logic signed [39:0]       nn_p [6];
  logic signed [39:0]       sn_p [3];
  logic signed [39:0]       tnn_p [6];
  logic signed [31:0]       nn_q [6];
  logic signed [CORD_W-1:0] sn_q [3];
  logic signed [CORD_W-1:0] sn2_q [3];
  logic signed [CORD_W-1:0] c1_q, c2_q;
  logic signed [34:0]       t_q;
  logic signed [35:0]       tnn_q [6];

  always_comb begin
    p1_sd   = cr_side[CORDIC_STAGES];
    p1_n[0] = $signed(p1_sd[95:64]);
    p1_n[1] = $signed(p1_sd[63:32]);
    p1_n[2] = $signed(p1_sd[31:0]);
    p1_c    = p1_sd[96] ? -cr_st[CORDIC_STAGES].x : cr_st[CORDIC_STAGES].x;
  end

  // order of nn: xx yy zz xy xz yz
  always_comb begin
    nn_p[0] = mulq(p1_n[0], p1_n[0]);
    nn_p[1] = mulq(p1_n[1], p1_n[1]);
    nn_p[2] = mulq(p1_n[2], p1_n[2]);
    nn_p[3] = mulq(p1_n[0], p1_n[1]);
    nn_p[4] = mulq(p1_n[0], p1_n[2]);
    nn_p[5] = mulq(p1_n[1], p1_n[2]);
    for (int l = 0; l < 3; l++) begin
      sn_p[l] = mulq(cr_st[CORDIC_STAGES].y, p1_n[l]);
    end
    for (int k = 0; k < 6; k++) begin
      tnn_p[k] = mulq(t_q, nn_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= cr_valid[CORDIC_STAGES];
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        nn_q[k]  <= nn_p[k][31:0];
        tnn_q[k] <= tnn_p[k][35:0];
      end
      for (int l = 0; l < 3; l++) begin
        sn_q[l] <= sn_p[l][CORD_W-1:0];
      end
      c1_q    <= p1_c;
      t_q     <= Q30_ONE - p1_c;
      p1_id_q <= p1_sd[97];
      sn2_q   <= sn_q;
      c2_q    <= c1_q;
      p2_id_q <= p1_id_q;
    end
  end

  // element sums, rounding to the output format, saturation, identity override
  logic signed [37:0] m  [9];
  logic signed [37:0] mr [9];
  logic [OUT_W-1:0]   mo [9];
  logic               out_valid_q;
  rvm_out_t           out_q;

  always_comb begin
    m[0] = c2_q + tnn_q[0];
    m[1] = tnn_q[3] - sn2_q[2];
    m[2] = tnn_q[4] + sn2_q[1];
    m[3] = tnn_q[3] + sn2_q[2];
    m[4] = c2_q + tnn_q[1];
    m[5] = tnn_q[5] - sn2_q[0];
    m[6] = tnn_q[4] - sn2_q[1];
    m[7] = tnn_q[5] + sn2_q[0];
    m[8] = c2_q + tnn_q[2];
    for (int k = 0; k < 9; k++) begin
      mr[k] = (m[k] + RND) >>> SH;
      if (mr[k] > ONE) begin
        mr[k] = ONE;
      end else if (mr[k] < -ONE) begin
        mr[k] = -ONE;
      end
      if (p2_id_q) begin
        mo[k] = (k % 4 == 0) ? ONE[OUT_W-1:0] : '0;
      end else begin
        mo[k] = mr[k][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {mo[0], mo[1], mo[2], mo[3], mo[4], mo[5], mo[6], mo[7], mo[8], p2_id_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // identity items carry a clean unit matrix
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.was_identity |->
      out_data_o.m01 == '0 && out_data_o.m12 == '0 &&
      out_data_o.m00 == ONE[OUT_W-1:0])
    else $error("identity item with wrong elements");

  // a held output freezes the last cordic cell
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(cr_valid[CORDIC_STAGES]))
    else $error("chain moved during stall");

  // a stall only happens with a result waiting
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q)
    else $error("stall without pending item");

endmodule
